>>> rtl/dbm_pkg.sv
// ----------------------------------------------------------------------------
// dbm_pkg
// Shared types and constants of the disk visibility bitmap: item kinds,
// register indexes, the sequencer state type and the stamp geometry record.
// ----------------------------------------------------------------------------
`default_nettype none

package dbm_pkg;

   // default store size
   localparam int MAX_COLS_DEF = 64;
   localparam int MAX_ROWS_DEF = 64;

   // field and datapath widths
   localparam int KIND_W      = 2;
   localparam int POS_W       = 8;
   localparam int RADIUS_W    = 10;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 7;
   localparam int COORD_W     = 10;  // signed tile coordinates and clip limits
   localparam int HALF_W      = 7;   // half side of the box, at most 64
   localparam int DY_W        = 7;   // row distance magnitude inside the box
   localparam int RSQ_W       = 2 * RADIUS_W;
   localparam int RQ_W        = 12;  // floor(radius_q4^2 / 256)
   localparam int DSQ_W       = 13;  // dy^2, at most 4096
   localparam int LIM_W       = 14;  // signed rq - dy^2
   localparam int SPAN_W      = 6;
   localparam int SPAN_MAX    = 63;  // rq stays below 64^2

   localparam logic [CSR_DATA_W-1:0] MAP_SIZE_RESET = 7'd64;

   // item kinds
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
   localparam logic [KIND_W-1:0] KIND_STAMP = 2'd1;
   localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_MAP_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAP_HEIGHT = 1'b1;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_WALK,
      ST_DRAIN,
      ST_QUERY
   } dbm_state_type;

   // geometry of the disk being stamped, fixed for the whole stamp
   typedef struct packed {
      logic signed [POS_W-1:0]   cx;
      logic signed [POS_W-1:0]   cy;
      logic        [RQ_W-1:0]    rq;
      logic signed [COORD_W-1:0] col_hi;
   } dbm_disk_type;

endpackage

`default_nettype wire

>>> rtl/dbm_row_ram.sv
// ----------------------------------------------------------------------------
// dbm_row_ram
// Row store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module dbm_row_ram #(
   parameter int DEPTH = dbm_pkg::MAX_ROWS_DEF,
   parameter int WIDTH = 2 * dbm_pkg::MAX_COLS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/dbm_row_mask.sv
// ----------------------------------------------------------------------------
// dbm_row_mask
// Row pipeline of a stamp: takes one row a cycle, works out the span of
// columns inside the disk and hands back a read request and a column mask
// lined up with the read data of the row store.
// ----------------------------------------------------------------------------
`default_nettype none

module dbm_row_mask #(
   parameter int MAX_COLS = dbm_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = dbm_pkg::MAX_ROWS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire dbm_pkg::dbm_disk_type       disk,
   input  wire logic                        in_valid,
   input  wire logic [$clog2(MAX_ROWS)-1:0] in_row,
   output      logic                        rd_en,
   output      logic [$clog2(MAX_ROWS)-1:0] rd_addr,
   output      logic                        wr_valid,
   output      logic [$clog2(MAX_ROWS)-1:0] wr_row,
   output      logic [MAX_COLS-1:0]         wr_mask,
   output      logic                        busy
);

   localparam int ROW_W   = $clog2(MAX_ROWS);
   localparam int COORD_W = dbm_pkg::COORD_W;
   localparam int POS_W   = dbm_pkg::POS_W;
   localparam int DY_W    = dbm_pkg::DY_W;
   localparam int DSQ_W   = dbm_pkg::DSQ_W;
   localparam int LIM_W   = dbm_pkg::LIM_W;
   localparam int RQ_W    = dbm_pkg::RQ_W;
   localparam int SPAN_W  = dbm_pkg::SPAN_W;

   // stage 1: row distance squared
   logic signed [COORD_W-1:0] dy;
   logic signed [COORD_W-1:0] dy_mag;
   logic [2*DY_W-1:0]         dsq_full;
   logic [DSQ_W-1:0]          dsq_in;
   logic [DSQ_W-1:0]          dsq_ff;
   logic [ROW_W-1:0]          row1_ff;
   logic                      v1_ff;

   // stage 2: span of the row
   logic signed [LIM_W-1:0]   lim;
   logic [SPAN_W-1:0]         span_in;
   logic                      empty_in;
   logic [SPAN_W-1:0]         span_ff;
   logic                      empty_ff;
   logic [ROW_W-1:0]          row2_ff;
   logic                      v2_ff;

   // stage 3: column mask
   logic signed [COORD_W-1:0] cx_ext;
   logic signed [COORD_W-1:0] span_ext;
   logic signed [COORD_W-1:0] lo;
   logic signed [COORD_W-1:0] hi;
   logic signed [COORD_W-1:0] col;
   logic [MAX_COLS-1:0]       mask;

   // distance from the disk centre row
   always_comb begin
      dy = $signed({{(COORD_W-POS_W){disk.cy[POS_W-1]}}, disk.cy})
         - $signed({{(COORD_W-ROW_W){1'b0}}, in_row});
      dy_mag   = dy[COORD_W-1] ? -dy : dy;
      dsq_full = dy_mag[DY_W-1:0] * dy_mag[DY_W-1:0];
      dsq_in   = dsq_full[DSQ_W-1:0];
   end

   // largest column offset k with k^2 <= rq - dy^2
   always_comb begin
      lim = $signed({{(LIM_W-RQ_W){1'b0}}, disk.rq})
          - $signed({{(LIM_W-DSQ_W){1'b0}}, dsq_ff});
      empty_in = lim[LIM_W-1];
      span_in  = '0;
      for (int k = 1; k <= dbm_pkg::SPAN_MAX; k++) begin
         if (lim >= $signed(LIM_W'(k * k))) begin
            span_in = SPAN_W'(k);
         end
      end
   end

   // columns within the span, clipped to the map
   always_comb begin
      cx_ext   = $signed({{(COORD_W-POS_W){disk.cx[POS_W-1]}}, disk.cx});
      span_ext = $signed({{(COORD_W-SPAN_W){1'b0}}, span_ff});
      lo       = cx_ext - span_ext;
      hi       = cx_ext + span_ext;
      col      = '0;
      mask     = '0;
      for (int x = 0; x < MAX_COLS; x++) begin
         col     = COORD_W'(x);
         mask[x] = !empty_ff && (col >= lo) && (col <= hi) && (col <= disk.col_hi);
      end
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      dsq_ff   <= dsq_in;
      row1_ff  <= in_row;
      span_ff  <= span_in;
      empty_ff <= empty_in;
      row2_ff  <= row1_ff;
   end

   // read the row one stage ahead of its write
   assign rd_en    = v1_ff;
   assign rd_addr  = row1_ff;
   assign wr_valid = v2_ff;
   assign wr_row   = row2_ff;
   assign wr_mask  = mask;
   assign busy     = v1_ff | v2_ff;

endmodule

`default_nettype wire

>>> rtl/disk_visibility_bitmap.sv
// ----------------------------------------------------------------------------
// disk_visibility_bitmap
// Visible and explored tile bitmaps with clear, disk stamp and tile query.
// ----------------------------------------------------------------------------
// Items enter on the req_ channel (valid/ready); only a query gives an item
// on the rsp_ channel. The csr_ port sets map width (index 0) and height
// (index 1); the user must see that it is written only while the block is
// idle, which the block does not enforce. Both bitmaps share one row store,
// one row per entry, with a registered read. A clear drops the per-row
// visible valid bits. A query reads its row at accept; its bits pass
// through the query state into an output register, which offers its item.
// A stamp runs a setup state and, if the clipped bounding box is not
// empty, walks the box one row a cycle through a read-modify-write
// pipeline, then drains it; the block is busy until the drain ends.
// Reset clears the valid bits of every row, so the store reads as all
// zero at once, with no clearing pass; the map size returns to 64 by 64.
// A query result waits in an output register while rsp_ready is low; other
// items are still accepted meanwhile, and a later query holds in the query
// state until the waiting result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module disk_visibility_bitmap #(
   parameter int MAX_COLS = dbm_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = dbm_pkg::MAX_ROWS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // items in
   input  wire logic                                req_valid,
   output      logic                                req_ready,
   input  wire logic [dbm_pkg::KIND_W-1:0]          req_kind,
   input  wire logic signed [dbm_pkg::POS_W-1:0]    req_pos_x,
   input  wire logic signed [dbm_pkg::POS_W-1:0]    req_pos_y,
   input  wire logic [dbm_pkg::RADIUS_W-1:0]        req_radius_q4,
   // results out
   output      logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   output      logic                                rsp_tile_visible,
   output      logic                                rsp_tile_explored,
   // register writes
   input  wire logic                                csr_wr_en,
   input  wire logic [dbm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [dbm_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int COL_W    = $clog2(MAX_COLS);
   localparam int ROW_W    = $clog2(MAX_ROWS);
   localparam int DATA_W   = 2 * MAX_COLS;
   localparam int COORD_W  = dbm_pkg::COORD_W;
   localparam int POS_W    = dbm_pkg::POS_W;
   localparam int HALF_W   = dbm_pkg::HALF_W;
   localparam int RADIUS_W = dbm_pkg::RADIUS_W;
   localparam int CSR_W    = dbm_pkg::CSR_DATA_W;
   localparam logic [COORD_W-1:0] COLS_C = COORD_W'(MAX_COLS);
   localparam logic [COORD_W-1:0] ROWS_C = COORD_W'(MAX_ROWS);

   dbm_pkg::dbm_state_type state_ff, state_in;

   // register file
   logic [CSR_W-1:0]          map_width_ff,  map_width_in;
   logic [CSR_W-1:0]          map_height_ff, map_height_in;
   logic [COORD_W-1:0]        col_lim;
   logic [COORD_W-1:0]        row_lim;

   // accept and captured item
   logic                      accept;
   logic                      do_clear;
   logic                      do_stamp;
   logic                      do_query;
   logic signed [POS_W-1:0]   cap_x_ff;
   logic signed [POS_W-1:0]   cap_y_ff;
   logic [RADIUS_W-1:0]       cap_r_ff;

   // query
   logic signed [COORD_W-1:0] qx;
   logic signed [COORD_W-1:0] qy;
   logic                      q_hit;
   logic                      q_hit_ff;
   logic [COL_W-1:0]          q_col_ff;
   logic [ROW_W-1:0]          q_row_ff;

   // stamp setup
   logic [RADIUS_W:0]         half_sum;
   logic signed [COORD_W-1:0] half_ext;
   logic signed [COORD_W-1:0] cy_ext;
   logic signed [COORD_W-1:0] top_raw;
   logic signed [COORD_W-1:0] bot_raw;
   logic signed [COORD_W-1:0] top;
   logic signed [COORD_W-1:0] bot;
   logic signed [COORD_W-1:0] row_hi;
   logic                      box_go;
   logic [dbm_pkg::RSQ_W-1:0] rsq;
   dbm_pkg::dbm_disk_type     disk_in;
   dbm_pkg::dbm_disk_type     disk_ff;
   logic [ROW_W-1:0]          row_ff;
   logic [ROW_W-1:0]          last_ff;

   // sequencer outputs
   logic                      setup_en;
   logic                      walk_en;
   logic                      rsp_load;

   // row pipeline and store
   logic                      mask_rd_en;
   logic [ROW_W-1:0]          mask_rd_addr;
   logic                      mask_wr_valid;
   logic [ROW_W-1:0]          mask_wr_row;
   logic [MAX_COLS-1:0]       mask_wr_mask;
   logic                      mask_busy;
   logic                      ram_rd_en;
   logic [ROW_W-1:0]          ram_rd_addr;
   logic [DATA_W-1:0]         ram_rd_data;
   logic [DATA_W-1:0]         ram_wr_data;
   logic [MAX_COLS-1:0]       rd_vis;
   logic [MAX_COLS-1:0]       rd_exp;
   logic [MAX_COLS-1:0]       old_vis;
   logic [MAX_COLS-1:0]       old_exp;
   logic [MAX_ROWS-1:0]       vis_valid_ff;
   logic [MAX_ROWS-1:0]       exp_valid_ff;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_vis_ff;
   logic                      rsp_exp_ff;
   logic                      q_vis;
   logic                      q_exp;

   // register writes
   always_comb begin
      map_width_in  = map_width_ff;
      map_height_in = map_height_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            dbm_pkg::CSR_MAP_WIDTH:  map_width_in  = csr_wdata;
            dbm_pkg::CSR_MAP_HEIGHT: map_height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= dbm_pkg::MAP_SIZE_RESET;
         map_height_ff <= dbm_pkg::MAP_SIZE_RESET;
      end else begin
         map_width_ff  <= map_width_in;
         map_height_ff <= map_height_in;
      end
   end

   // map size in use, limited to the store
   assign col_lim = ({{(COORD_W-CSR_W){1'b0}}, map_width_ff} > COLS_C)
                  ? COLS_C : {{(COORD_W-CSR_W){1'b0}}, map_width_ff};
   assign row_lim = ({{(COORD_W-CSR_W){1'b0}}, map_height_ff} > ROWS_C)
                  ? ROWS_C : {{(COORD_W-CSR_W){1'b0}}, map_height_ff};

   // item decode
   always_comb begin
      accept   = req_valid && req_ready;
      do_clear = 1'b0;
      do_stamp = 1'b0;
      do_query = 1'b0;
      if (accept) begin
         unique case (req_kind)
            dbm_pkg::KIND_CLEAR: do_clear = 1'b1;
            dbm_pkg::KIND_STAMP: do_stamp = 1'b1;
            dbm_pkg::KIND_QUERY: do_query = 1'b1;
            default: ;
         endcase
      end
   end

   // query tile on the map
   always_comb begin
      qx    = $signed({{(COORD_W-POS_W){req_pos_x[POS_W-1]}}, req_pos_x});
      qy    = $signed({{(COORD_W-POS_W){req_pos_y[POS_W-1]}}, req_pos_y});
      q_hit = !qx[COORD_W-1] && !qy[COORD_W-1]
           && (qx < $signed(col_lim)) && (qy < $signed(row_lim));
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cap_x_ff <= req_pos_x;
         cap_y_ff <= req_pos_y;
         cap_r_ff <= req_radius_q4;
         q_hit_ff <= q_hit;
         q_col_ff <= qx[COL_W-1:0];
         q_row_ff <= qy[ROW_W-1:0];
      end
   end

   // bounding box, clipped rows, and disk geometry for the row pipeline
   always_comb begin
      half_sum = {1'b0, cap_r_ff} + (RADIUS_W+1)'(15);
      half_ext = $signed({{(COORD_W-HALF_W){1'b0}}, half_sum[RADIUS_W:4]});
      cy_ext   = $signed({{(COORD_W-POS_W){cap_y_ff[POS_W-1]}}, cap_y_ff});
      top_raw  = cy_ext - half_ext;
      bot_raw  = cy_ext + half_ext;
      row_hi   = $signed(row_lim) - $signed(COORD_W'(1));
      top      = top_raw[COORD_W-1] ? '0 : top_raw;
      bot      = (bot_raw > row_hi) ? row_hi : bot_raw;
      box_go   = (top <= bot);
      rsq      = cap_r_ff * cap_r_ff;
      disk_in.cx     = cap_x_ff;
      disk_in.cy     = cap_y_ff;
      disk_in.rq     = rsq[dbm_pkg::RSQ_W-1:dbm_pkg::RSQ_W-dbm_pkg::RQ_W];
      disk_in.col_hi = $signed(col_lim) - $signed(COORD_W'(1));
   end

   // row walk
   always_ff @(posedge clock) begin
      if (setup_en) begin
         disk_ff <= disk_in;
         row_ff  <= top[ROW_W-1:0];
         last_ff <= bot[ROW_W-1:0];
      end else if (walk_en) begin
         row_ff  <= row_ff + 1'b1;
      end
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dbm_pkg::ST_IDLE: begin
            if (do_stamp) begin
               state_in = dbm_pkg::ST_SETUP;
            end else if (do_query) begin
               state_in = dbm_pkg::ST_QUERY;
            end
         end
         dbm_pkg::ST_SETUP: begin
            state_in = box_go ? dbm_pkg::ST_WALK : dbm_pkg::ST_IDLE;
         end
         dbm_pkg::ST_WALK: begin
            if (row_ff == last_ff) begin
               state_in = dbm_pkg::ST_DRAIN;
            end
         end
         dbm_pkg::ST_DRAIN: begin
            if (!mask_busy) begin
               state_in = dbm_pkg::ST_IDLE;
            end
         end
         dbm_pkg::ST_QUERY: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = dbm_pkg::ST_IDLE;
            end
         end
         default: state_in = dbm_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = (state_ff == dbm_pkg::ST_IDLE);
      setup_en  = (state_ff == dbm_pkg::ST_SETUP);
      walk_en   = (state_ff == dbm_pkg::ST_WALK);
      rsp_load  = (state_ff == dbm_pkg::ST_QUERY) && (!rsp_valid_ff || rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dbm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   dbm_row_mask #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_row_mask (
      .clock    (clock),
      .reset    (reset),
      .disk     (disk_ff),
      .in_valid (walk_en),
      .in_row   (row_ff),
      .rd_en    (mask_rd_en),
      .rd_addr  (mask_rd_addr),
      .wr_valid (mask_wr_valid),
      .wr_row   (mask_wr_row),
      .wr_mask  (mask_wr_mask),
      .busy     (mask_busy)
   );

   // store read: a query at accept, otherwise the row pipeline
   assign ram_rd_en   = do_query || mask_rd_en;
   assign ram_rd_addr = do_query ? qy[ROW_W-1:0] : mask_rd_addr;

   // merge the stamp mask into the row read in the cycle before
   always_comb begin
      rd_vis      = ram_rd_data[MAX_COLS-1:0];
      rd_exp      = ram_rd_data[DATA_W-1:MAX_COLS];
      old_vis     = vis_valid_ff[mask_wr_row] ? rd_vis : '0;
      old_exp     = exp_valid_ff[mask_wr_row] ? rd_exp : '0;
      ram_wr_data = {old_exp | mask_wr_mask, old_vis | mask_wr_mask};
   end

   dbm_row_ram #(
      .DEPTH (MAX_ROWS),
      .WIDTH (DATA_W)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (mask_wr_valid),
      .wr_addr (mask_wr_row),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // row valid bits: rows unwritten since reset read zero; clear drops only visible
   always_ff @(posedge clock) begin
      if (reset) begin
         vis_valid_ff <= '0;
         exp_valid_ff <= '0;
      end else begin
         if (do_clear) begin
            vis_valid_ff <= '0;
         end else if (mask_wr_valid) begin
            vis_valid_ff[mask_wr_row] <= 1'b1;
         end
         if (mask_wr_valid) begin
            exp_valid_ff[mask_wr_row] <= 1'b1;
         end
      end
   end

   // query bits from the row read at accept
   always_comb begin
      q_vis = q_hit_ff && vis_valid_ff[q_row_ff] && rd_vis[q_col_ff];
      q_exp = q_hit_ff && exp_valid_ff[q_row_ff] && rd_exp[q_col_ff];
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_vis_ff <= q_vis;
         rsp_exp_ff <= q_exp;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_tile_visible  = rsp_vis_ff;
   assign rsp_tile_explored = rsp_exp_ff;

endmodule

`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the disk visibility bitmap. A local copy of both
// tile maps follows every accepted clear, stamp and query item, and each
// query result is checked against the oldest expected tile. Directed tests
// cover the field extremes and map size corners, then random phases run
// across several map sizes with random idling on both channels.
// ----------------------------------------------------------------------------

module testbench;

   localparam int COLS        = dbm_pkg::MAX_COLS_DEF;
   localparam int ROWS        = dbm_pkg::MAX_ROWS_DEF;
   localparam int KIND_W      = dbm_pkg::KIND_W;
   localparam int POS_W       = dbm_pkg::POS_W;
   localparam int RADIUS_W    = dbm_pkg::RADIUS_W;
   localparam int CSR_INDEX_W = dbm_pkg::CSR_INDEX_W;
   localparam int CSR_DATA_W  = dbm_pkg::CSR_DATA_W;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   // settle time covers a stamp over the full height of the store and its drain
   localparam int SETTLE_CYCLES = ROWS + 16;
   // longest quiet stretch: hold-off, a full stamp and both stalls, with margin
   localparam int QUIET_LIMIT = 2000;
   localparam int PHASE_ITEMS = 200;
   localparam int PHASE_COUNT = 8;

   typedef struct {
      logic visible;
      logic explored;
   } tile_bits_type;

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [KIND_W-1:0]          req_kind = dbm_pkg::KIND_CLEAR;
   logic signed [POS_W-1:0]    req_pos_x = '0;
   logic signed [POS_W-1:0]    req_pos_y = '0;
   logic [RADIUS_W-1:0]        req_radius_q4 = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic                       rsp_tile_visible;
   logic                       rsp_tile_explored;
   logic                       csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0]     csr_index = dbm_pkg::CSR_MAP_WIDTH;
   logic [CSR_DATA_W-1:0]      csr_wdata = '0;

   // mirror of the block state
   logic [COLS-1:0]            visible_map [ROWS];
   logic [COLS-1:0]            explored_map [ROWS];
   logic [CSR_DATA_W-1:0]      map_width;
   logic [CSR_DATA_W-1:0]      map_height;
   tile_bits_type              expected_tiles [$];

   bit                         no_idle = 1'b0;
   int                         error_count = 0;
   int                         items_sent = 0;
   int                         stamps_sent = 0;
   int                         queries_sent = 0;
   int                         tiles_checked = 0;
   int                         size_settings = 0;
   int                         quiet_cycles = 0;

   disk_visibility_bitmap DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_radius_q4     (req_radius_q4),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_tile_visible  (rsp_tile_visible),
      .rsp_tile_explored (rsp_tile_explored),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // map size as the block sees it, clamped to the store
   function automatic int cols_in_use();
      return (map_width > COLS) ? COLS : int'(map_width);
   endfunction

   function automatic int rows_in_use();
      return (map_height > ROWS) ? ROWS : int'(map_height);
   endfunction

   function automatic int draw_gap();
      return no_idle ? 0 : int'($urandom_range(0, 11));
   endfunction

   // mark every in-map tile within the radius, exact integer distance test
   function automatic void stamp_disk(int cx, int cy, int r_q4);
      int half;
      int left;
      int right;
      int top;
      int bottom;
      int limit;
      int d2;
      half   = (r_q4 + 15) >> 4;
      left   = (cx - half < 0) ? 0 : cx - half;
      top    = (cy - half < 0) ? 0 : cy - half;
      right  = (cx + half > cols_in_use() - 1) ? cols_in_use() - 1 : cx + half;
      bottom = (cy + half > rows_in_use() - 1) ? rows_in_use() - 1 : cy + half;
      limit  = r_q4 * r_q4;
      for (int y = top; y <= bottom; y++) begin
         for (int x = left; x <= right; x++) begin
            d2 = (cx - x) * (cx - x) + (cy - y) * (cy - y);
            if (d2 * 256 <= limit) begin
               visible_map[y][x]  = 1'b1;
               explored_map[y][x] = 1'b1;
            end
         end
      end
   endfunction

   // advance the tile maps by one accepted item, queue a query's answer
   function automatic void update_tile_maps(logic [KIND_W-1:0] kind, int x, int y, int r_q4);
      tile_bits_type tile;
      case (kind)
         dbm_pkg::KIND_CLEAR: begin
            foreach (visible_map[i]) visible_map[i] = '0;
         end
         dbm_pkg::KIND_STAMP: begin
            stamp_disk(x, y, r_q4);
            stamps_sent++;
         end
         dbm_pkg::KIND_QUERY: begin
            tile.visible  = 1'b0;
            tile.explored = 1'b0;
            if (x >= 0 && x < cols_in_use() && y >= 0 && y < rows_in_use()) begin
               tile.visible  = visible_map[y][x];
               tile.explored = explored_map[y][x];
            end
            expected_tiles.push_back(tile);
            queries_sent++;
         end
         default: ;
      endcase
   endfunction

   // send one item; returns at the falling edge after it is accepted
   task automatic send_item(logic [KIND_W-1:0] kind, int x, int y, int r_q4);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_pos_x     <= POS_W'(x);
      req_pos_y     <= POS_W'(y);
      req_radius_q4 <= RADIUS_W'(r_q4);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      update_tile_maps(req_kind, int'(req_pos_x), int'(req_pos_y), int'(req_radius_q4));
      items_sent++;
      @(negedge clock);
   endtask

   // hold the sender until every query is answered and any stamp has drained
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_tiles.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // write both size registers on consecutive cycles
   task automatic set_map_size(int w, int h);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_index <= dbm_pkg::CSR_MAP_WIDTH;
      csr_wdata <= CSR_DATA_W'(w);
      @(negedge clock);
      csr_index <= dbm_pkg::CSR_MAP_HEIGHT;
      csr_wdata <= CSR_DATA_W'(h);
      @(negedge clock);
      csr_wr_en  <= 1'b0;
      map_width  = CSR_DATA_W'(w);
      map_height = CSR_DATA_W'(h);
      size_settings++;
   endtask

   // result side: random stall per item, compare with the oldest expected tile
   initial begin
      tile_bits_type want;
      int            stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         if (expected_tiles.size() == 0) begin
            $error("unexpected result item: tile_visible %0b tile_explored %0b",
                   rsp_tile_visible, rsp_tile_explored);
            error_count++;
         end else begin
            want = expected_tiles.pop_front();
            if (rsp_tile_visible !== want.visible) begin
               $error("tile_visible mismatch: expected %0b, actual %0b",
                      want.visible, rsp_tile_visible);
               error_count++;
            end
            if (rsp_tile_explored !== want.explored) begin
               $error("tile_explored mismatch: expected %0b, actual %0b",
                      want.explored, rsp_tile_explored);
               error_count++;
            end
            tiles_checked++;
         end
         @(negedge clock);
      end
   end

   // watchdog on cycles with no accepted item and no register write
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // store reads as zero right after reset
   task automatic test_after_reset();
      send_item(dbm_pkg::KIND_QUERY, 0, 0, 0);
      send_item(dbm_pkg::KIND_QUERY, COLS - 1, ROWS - 1, 0);
   endtask

   // radius and position extremes, off-map queries and the unused kind
   task automatic test_stamp_and_query();
      send_item(dbm_pkg::KIND_STAMP, 10, 10, 0);
      send_item(dbm_pkg::KIND_QUERY, 10, 10, 0);
      send_item(dbm_pkg::KIND_QUERY, 11, 10, 0);
      // fractional radius of one and a half tiles
      send_item(dbm_pkg::KIND_STAMP, 32, 32, 24);
      send_item(dbm_pkg::KIND_QUERY, 33, 33, 0);
      send_item(dbm_pkg::KIND_QUERY, 34, 32, 1023);
      // centres far off the map at both extremes, then one on a map corner
      send_item(dbm_pkg::KIND_STAMP, -128, -128, 1023);
      send_item(dbm_pkg::KIND_STAMP, 127, 127, 1023);
      send_item(dbm_pkg::KIND_STAMP, 0, ROWS - 1, 1023);
      send_item(dbm_pkg::KIND_QUERY, COLS - 1, 0, 0);
      send_item(dbm_pkg::KIND_QUERY, -1, 5, 0);
      send_item(dbm_pkg::KIND_QUERY, COLS, 0, 0);
      send_item(dbm_pkg::KIND_QUERY, 127, -128, 0);
      send_item(KIND_UNUSED, 60, 0, 1023);
      send_item(dbm_pkg::KIND_QUERY, 60, 0, 0);
   endtask

   // clear drops visible bits and keeps explored ones
   task automatic test_clear();
      send_item(dbm_pkg::KIND_CLEAR, 0, 0, 0);
      send_item(dbm_pkg::KIND_QUERY, 10, 10, 0);
      send_item(dbm_pkg::KIND_STAMP, 20, 20, 16);
      send_item(dbm_pkg::KIND_QUERY, 20, 20, 0);
   endtask

   // small map, oversized map and empty map
   task automatic test_map_size();
      set_map_size(16, 8);
      send_item(dbm_pkg::KIND_QUERY, 10, 10, 0);
      send_item(dbm_pkg::KIND_STAMP, 15, 7, 1023);
      send_item(dbm_pkg::KIND_QUERY, 15, 7, 0);
      set_map_size(127, 127);
      send_item(dbm_pkg::KIND_QUERY, 15, 7, 0);
      send_item(dbm_pkg::KIND_QUERY, COLS - 1, ROWS - 1, 0);
      set_map_size(0, 0);
      send_item(dbm_pkg::KIND_STAMP, 0, 0, 1023);
      send_item(dbm_pkg::KIND_QUERY, 0, 0, 0);
   endtask

   // mostly near the map, now and then anywhere in the field range
   function automatic int draw_pos(int span);
      if ($urandom_range(0, 9) == 0) return int'($urandom_range(0, 255)) - 128;
      return int'($urandom_range(0, span + 7)) - 4;
   endfunction

   // random phases over a spread of map sizes
   task automatic test_random();
      int               w;
      int               h;
      int               sent;
      int               roll;
      int               r_q4;
      logic [KIND_W-1:0] kind;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin w = 64;  h = 64;  end
            1: begin w = 1;   h = 64;  end
            2: begin w = 64;  h = 1;   end
            3: begin w = 0;   h = 0;   end
            4: begin w = 127; h = 127; end
            5: begin w = 8;   h = 40;  end
            default: begin
               w = $urandom_range(0, 127);
               h = $urandom_range(0, 127);
            end
         endcase
         set_map_size(w, h);
         no_idle = (phase == 6);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 6) kind = dbm_pkg::KIND_CLEAR;
            else if (roll < 36) kind = dbm_pkg::KIND_STAMP;
            else if (roll < 97) kind = dbm_pkg::KIND_QUERY;
            else kind = KIND_UNUSED;
            r_q4 = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                                : $urandom_range(0, 160);
            send_item(kind, draw_pos(cols_in_use()), draw_pos(rows_in_use()), r_q4);
            if (kind != KIND_UNUSED) sent++;
            // drain everything halfway through each phase
            if (sent == PHASE_ITEMS / 2) wait_idle();
         end
         no_idle = 1'b0;
      end
   endtask

   initial begin
      foreach (visible_map[i]) begin
         visible_map[i]  = '0;
         explored_map[i] = '0;
      end
      map_width  = dbm_pkg::MAP_SIZE_RESET;
      map_height = dbm_pkg::MAP_SIZE_RESET;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_after_reset();
      test_stamp_and_query();
      test_clear();
      test_map_size();
      test_random();
      wait_idle();

      $display("covered %0d items (%0d stamps, %0d queries), %0d tiles checked",
               items_sent, stamps_sent, queries_sent, tiles_checked);
      $display("across %0d map size settings, %0d errors", size_settings, error_count);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
